@@ sv/rvb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvb_pkg
// Shared widths, constants, register codes and stage words of the RAVE
// value blend pipeline.
// ----------------------------------------------------------------------------
package rvb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 32;

    localparam int FW   = FRAC_BITS + 1;      // fraction field width
    localparam int CW   = COUNT_BITS;         // count width
    localparam int EQW  = 20;                 // equivalence register width
    localparam int THW  = 32;                 // threshold register width
    localparam int IDXW = 8;                  // config index width
    localparam int DATW = 32;                 // config data width
    localparam int XW   = 2 * FRAC_BITS + 4;  // criticality term width (signed)
    localparam int QS   = FW + 1;             // AMAF mean quotient steps
    localparam int NUMW = FW + CW + 1;        // AMAF mean dividend width
    localparam int PW   = 2 * CW;             // product / denominator width
    localparam int TS   = PW;                 // product/equivalence steps
    localparam int BS   = FW;                 // weight quotient steps

    localparam logic [FW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FW-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

    localparam logic [EQW-1:0] EQUIV_RESET  = EQW'(3000);
    localparam logic [THW-1:0] THRESH_RESET = '0;

    localparam logic [IDXW-1:0] CFG_EQUIV  = IDXW'(0);
    localparam logic [IDXW-1:0] CFG_THRESH = IDXW'(1);

    typedef struct packed {
        logic [EQW-1:0] equiv;
        logic [THW-1:0] thresh;
    } cfg_t;

    typedef struct packed {
        logic [CW-1:0]   n;
        logic [CW-1:0]   nr;
        logic [FW-1:0]   q;
        logic [FW-1:0]   aq;
        logic            use_div;
        logic [NUMW-1:0] num;
        logic [EQW-1:0]  eq;
        logic [PW-1:0]   prod;
    } front_out_t;

    typedef struct packed {
        logic [CW-1:0] n;
        logic [CW-1:0] nr;
        logic [FW-1:0] q;
        logic [FW-1:0] qa;
        logic [PW-1:0] t;
    } tdiv_out_t;

    typedef struct packed {
        logic [FW-1:0] q;
        logic [FW-1:0] qa;
        logic [FW-1:0] b;
    } bdiv_out_t;

    function automatic logic [FW-1:0] frac_clamp(input logic [FW-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

endpackage

@@ sv/rvb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvb_front
// Five stages: input clamp, criticality term, criticality products,
// raised AMAF count and dividend, visit product.
// ----------------------------------------------------------------------------
module rvb_front import rvb_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  cfg_t            cfg,
    input  logic            in_valid,
    input  logic [CW-1:0]   in_visit_count,
    input  logic [FW-1:0]   in_mean_value,
    input  logic [CW-1:0]   in_amaf_count,
    input  logic [FW-1:0]   in_amaf_mean,
    input  logic [FW-1:0]   in_owner_win_rate,
    input  logic [FW-1:0]   in_color_own_rate,
    output logic            out_valid,
    output front_out_t      out_word
);

    typedef struct packed {
        logic [CW-1:0]   n;
        logic [CW-1:0]   an;
        logic [FW-1:0]   q;
        logic [FW-1:0]   aq;
        logic [FW-1:0]   ow;
        logic [FW-1:0]   co;
        logic [2*FW-1:0] coq;
        logic            crit_en;
        logic [EQW-1:0]  eq;
    } s1_t;

    typedef struct packed {
        logic [CW-1:0]  n;
        logic [CW-1:0]  an;
        logic [FW-1:0]  q;
        logic [FW-1:0]  aq;
        logic [FW-1:0]  cm;
        logic           pos;
        logic [EQW-1:0] eq;
    } s2_t;

    typedef struct packed {
        logic [CW-1:0]    n;
        logic [CW-1:0]    an;
        logic [FW-1:0]    q;
        logic [FW-1:0]    aq;
        logic             pos;
        logic [FW+CW-1:0] crit;
        logic [FW+CW-1:0] aqan;
        logic [EQW-1:0]   eq;
    } s3_t;

    typedef struct packed {
        logic [CW-1:0]   n;
        logic [CW-1:0]   nr;
        logic [FW-1:0]   q;
        logic [FW-1:0]   aq;
        logic            use_div;
        logic [NUMW-1:0] num;
        logic [EQW-1:0]  eq;
    } s4_t;

    s1_t        s1_reg, s1_next;
    s2_t        s2_reg, s2_next;
    s3_t        s3_reg, s3_next;
    s4_t        s4_reg, s4_next;
    front_out_t s5_reg, s5_next;
    logic [4:0] vld_reg;

    logic signed [XW-1:0] c2;
    logic        [XW-1:0] mag;
    logic        [CW:0]   nr_sum;

    always_comb begin
        s1_next.n       = in_visit_count;
        s1_next.an      = in_amaf_count;
        s1_next.q       = frac_clamp(in_mean_value);
        s1_next.aq      = frac_clamp(in_amaf_mean);
        s1_next.ow      = frac_clamp(in_owner_win_rate);
        s1_next.co      = frac_clamp(in_color_own_rate);
        s1_next.coq     = frac_clamp(in_color_own_rate) * frac_clamp(in_mean_value);
        s1_next.crit_en = (cfg.thresh != '0) && (in_visit_count >= cfg.thresh);
        s1_next.eq      = (cfg.equiv == '0) ? EQW'(1) : cfg.equiv;
    end

    // c = ow - (2*co*q - co - q + 1), kept with 2*FRAC_BITS fraction bits
    always_comb begin
        c2 = $signed((XW'(s1_reg.ow) << FRAC_BITS) + (XW'(s1_reg.co) << FRAC_BITS)
                     + (XW'(s1_reg.q) << FRAC_BITS))
           - $signed((XW'(s1_reg.coq) << 1) + (XW'(1) << (2 * FRAC_BITS)));
        mag = c2[XW-1] ? XW'(-c2) : XW'(c2);
        s2_next.n   = s1_reg.n;
        s2_next.an  = s1_reg.an;
        s2_next.q   = s1_reg.q;
        s2_next.aq  = s1_reg.aq;
        s2_next.cm  = s1_reg.crit_en ? mag[2*FRAC_BITS:FRAC_BITS] : '0;
        s2_next.pos = s1_reg.crit_en && !c2[XW-1] && (c2 != '0);
        s2_next.eq  = s1_reg.eq;
    end

    always_comb begin
        s3_next.n    = s2_reg.n;
        s3_next.an   = s2_reg.an;
        s3_next.q    = s2_reg.q;
        s3_next.aq   = s2_reg.aq;
        s3_next.pos  = s2_reg.pos;
        s3_next.crit = s2_reg.cm * s2_reg.an;
        s3_next.aqan = s2_reg.aq * s2_reg.an;
        s3_next.eq   = s2_reg.eq;
    end

    always_comb begin
        nr_sum = (CW + 1)'(s3_reg.an) + s3_reg.crit[FW+CW-1:FRAC_BITS];
        s4_next.n  = s3_reg.n;
        s4_next.nr = nr_sum[CW] ? {CW{1'b1}} : nr_sum[CW-1:0];
        s4_next.q  = s3_reg.q;
        s4_next.aq = s3_reg.aq;
        s4_next.use_div = s3_reg.pos && (s4_next.nr != '0);
        s4_next.num = NUMW'(s3_reg.aqan) + NUMW'(s3_reg.crit);
        s4_next.eq  = s3_reg.eq;
    end

    always_comb begin
        s5_next.n       = s4_reg.n;
        s5_next.nr      = s4_reg.nr;
        s5_next.q       = s4_reg.q;
        s5_next.aq      = s4_reg.aq;
        s5_next.use_div = s4_reg.use_div;
        s5_next.num     = s4_reg.num;
        s5_next.eq      = s4_reg.eq;
        s5_next.prod    = s4_reg.n * s4_reg.nr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_word  = s5_reg;

endmodule

@@ sv/rvb_tdiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvb_tdiv
// Bit-per-stage restoring dividers: visit product by equivalence over all
// stages, raised AMAF mean over the first stages.
// ----------------------------------------------------------------------------
module rvb_tdiv import rvb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  front_out_t in_word,
    output logic       out_valid,
    output tdiv_out_t  out_word
);

    typedef struct packed {
        logic [CW-1:0]  n;
        logic [CW-1:0]  nr;
        logic [FW-1:0]  q;
        logic [FW-1:0]  aq;
        logic           use_div;
        logic [CW-1:0]  qa_rem;
        logic [QS-1:0]  qa_low;
        logic [EQW-1:0] t_rem;
        logic [PW-1:0]  t_pq;
        logic [EQW-1:0] eq;
    } tstage_t;

    tstage_t        st_reg  [TS];
    tstage_t        st_next [TS];
    logic [TS-1:0]  vld_reg;

    always_comb begin
        tstage_t      src;
        logic [EQW:0] tr;
        logic [CW:0]  qr;
        for (int i = 0; i < TS; i++) begin
            if (i == 0) begin
                src.n       = in_word.n;
                src.nr      = in_word.nr;
                src.q       = in_word.q;
                src.aq      = in_word.aq;
                src.use_div = in_word.use_div;
                src.qa_rem  = in_word.num[NUMW-1:QS];
                src.qa_low  = in_word.num[QS-1:0];
                src.t_rem   = '0;
                src.t_pq    = in_word.prod;
                src.eq      = in_word.eq;
            end else begin
                src = st_reg[i-1];
            end
            st_next[i] = src;
            tr = {src.t_rem, src.t_pq[PW-1]};
            if (tr >= {1'b0, src.eq}) begin
                tr = tr - {1'b0, src.eq};
                st_next[i].t_pq = {src.t_pq[PW-2:0], 1'b1};
            end else begin
                st_next[i].t_pq = {src.t_pq[PW-2:0], 1'b0};
            end
            st_next[i].t_rem = tr[EQW-1:0];
            if (i < QS) begin
                qr = {src.qa_rem, src.qa_low[QS-1]};
                if (qr >= {1'b0, src.nr}) begin
                    qr = qr - {1'b0, src.nr};
                    st_next[i].qa_low = {src.qa_low[QS-2:0], 1'b1};
                end else begin
                    st_next[i].qa_low = {src.qa_low[QS-2:0], 1'b0};
                end
                st_next[i].qa_rem = qr[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < TS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_comb begin
        out_word.n  = st_reg[TS-1].n;
        out_word.nr = st_reg[TS-1].nr;
        out_word.q  = st_reg[TS-1].q;
        out_word.t  = st_reg[TS-1].t_pq;
        if (!st_reg[TS-1].use_div) begin
            out_word.qa = st_reg[TS-1].aq;
        end else if (st_reg[TS-1].qa_low > {1'b0, ONE}) begin
            out_word.qa = ONE;
        end else begin
            out_word.qa = st_reg[TS-1].qa_low[FW-1:0];
        end
    end

    assign out_valid = vld_reg[TS-1];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (st_reg[TS-1].t_rem < st_reg[TS-1].eq))
        else $error("equivalence remainder not below divisor");

    a_qa_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_word.qa <= ONE))
        else $error("raised AMAF mean above one");

endmodule

@@ sv/rvb_bdiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvb_bdiv
// Saturating weight denominator, then bit-per-stage division of the raised
// AMAF count by it to form the blend weight.
// ----------------------------------------------------------------------------
module rvb_bdiv import rvb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  tdiv_out_t in_word,
    output logic      out_valid,
    output bdiv_out_t out_word
);

    typedef struct packed {
        logic [FW-1:0] q;
        logic [FW-1:0] qa;
        logic [PW-1:0] d;
        logic          dz;
        logic [PW-1:0] rem;
        logic [FW-1:0] low;
    } bstage_t;

    bstage_t       dst_reg, dst_next;
    bstage_t       st_reg  [BS];
    bstage_t       st_next [BS];
    logic          dvld_reg;
    logic [BS-1:0] vld_reg;
    logic [PW:0]   d_sum;

    always_comb begin
        d_sum = (PW + 1)'(in_word.n) + (PW + 1)'(in_word.nr) + (PW + 1)'(in_word.t);
        dst_next.q   = in_word.q;
        dst_next.qa  = in_word.qa;
        dst_next.d   = d_sum[PW] ? {PW{1'b1}} : d_sum[PW-1:0];
        dst_next.dz  = (d_sum == '0);
        dst_next.rem = PW'(in_word.nr >> 1);
        dst_next.low = {in_word.nr[0], {FRAC_BITS{1'b0}}};
    end

    always_comb begin
        bstage_t     src;
        logic [PW:0] r;
        for (int i = 0; i < BS; i++) begin
            if (i == 0) begin
                src = dst_reg;
            end else begin
                src = st_reg[i-1];
            end
            st_next[i] = src;
            r = {src.rem, src.low[FW-1]};
            if (r >= {1'b0, src.d}) begin
                r = r - {1'b0, src.d};
                st_next[i].low = {src.low[FW-2:0], 1'b1};
            end else begin
                st_next[i].low = {src.low[FW-2:0], 1'b0};
            end
            st_next[i].rem = r[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg <= 1'b0;
            vld_reg  <= '0;
        end else if (en) begin
            dvld_reg <= in_valid;
            vld_reg  <= {vld_reg[BS-2:0], dvld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dst_reg <= dst_next;
            for (int i = 0; i < BS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_comb begin
        out_word.q  = st_reg[BS-1].q;
        out_word.qa = st_reg[BS-1].qa;
        if (st_reg[BS-1].dz) begin
            out_word.b = '0;
        end else begin
            out_word.b = frac_clamp(st_reg[BS-1].low);
        end
    end

    assign out_valid = vld_reg[BS-1];

endmodule

@@ sv/rvb_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvb_blend
// Weighted mix of playout and AMAF means with round half up, into the
// output register.
// ----------------------------------------------------------------------------
module rvb_blend import rvb_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  bdiv_out_t     in_word,
    output logic          out_valid,
    output logic [FW-1:0] out_value
);

    logic [2*FW-1:0] p0_reg, p0_next;
    logic [2*FW-1:0] p1_reg, p1_next;
    logic [FW-1:0]   res_reg, res_next;
    logic [2*FW:0]   acc;
    logic            mvld_reg;
    logic            ovld_reg;

    assign p0_next = (ONE - in_word.b) * in_word.q;
    assign p1_next = in_word.b * in_word.qa;

    always_comb begin
        acc = (2 * FW + 1)'(p0_reg) + (2 * FW + 1)'(p1_reg) + (2 * FW + 1)'(HALF);
        res_next = acc[FRAC_BITS+FW-1:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvld_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end else if (en) begin
            mvld_reg <= in_valid;
            ovld_reg <= mvld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = ovld_reg;
    assign out_value = res_reg;

endmodule

@@ sv/rave_value_blend_top.sv @@
`timescale 1ns / 1ps
// Pipeline: 5 front stages, 64 equivalence divide stages, 18 weight stages
// and 2 blend stages between input accept and result valid.
// Throughput: one word per cycle while not stalled; one shared stall enable
// moves all stages, set by the output register being empty or taken.
// Reset: synchronous active-low aresetn clears all valid bits and loads the
// configuration registers with their defaults (equivalence 3000, threshold 0).
// ----------------------------------------------------------------------------
// rave_value_blend_top
// RAVE blended move value with minimum-MSE weight and criticality raise.
// ----------------------------------------------------------------------------
module rave_value_blend_top import rvb_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [IDXW-1:0] cfg_index,
    input  logic [DATW-1:0] cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [CW-1:0]   s_visit_count,
    input  logic [FW-1:0]   s_mean_value,
    input  logic [CW-1:0]   s_amaf_count,
    input  logic [FW-1:0]   s_amaf_mean,
    input  logic [FW-1:0]   s_owner_win_rate,
    input  logic [FW-1:0]   s_color_own_rate,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [FW-1:0]   m_blended_value
);

    cfg_t       cfg_reg;
    logic       en;
    logic       f_valid, t_valid, b_valid;
    front_out_t f_word;
    tdiv_out_t  t_word;
    bdiv_out_t  b_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.equiv  <= EQUIV_RESET;
            cfg_reg.thresh <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_EQUIV:  cfg_reg.equiv  <= cfg_wdata[EQW-1:0];
                CFG_THRESH: cfg_reg.thresh <= cfg_wdata[THW-1:0];
                default: ;
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rvb_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .cfg               (cfg_reg),
        .in_valid          (s_valid),
        .in_visit_count    (s_visit_count),
        .in_mean_value     (s_mean_value),
        .in_amaf_count     (s_amaf_count),
        .in_amaf_mean      (s_amaf_mean),
        .in_owner_win_rate (s_owner_win_rate),
        .in_color_own_rate (s_color_own_rate),
        .out_valid         (f_valid),
        .out_word          (f_word)
    );

    rvb_tdiv u_tdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_word   (f_word),
        .out_valid (t_valid),
        .out_word  (t_word)
    );

    rvb_bdiv u_bdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t_valid),
        .in_word   (t_word),
        .out_valid (b_valid),
        .out_word  (b_word)
    );

    rvb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid),
        .in_word   (b_word),
        .out_valid (m_valid),
        .out_value (m_blended_value)
    );

endmodule

@@ dv/rave_value_blend_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rave_value_blend_checker
// Watches both streams of the blend block, computes each expected blended
// value from the accepted input word and the current register settings,
// and compares it with the output words in order.
// ----------------------------------------------------------------------------
module rave_value_blend_checker import rvb_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [IDXW-1:0] cfg_index,
    input  logic [DATW-1:0] cfg_wdata,
    input  logic            s_valid,
    input  logic            s_ready,
    input  logic [CW-1:0]   s_visit_count,
    input  logic [FW-1:0]   s_mean_value,
    input  logic [CW-1:0]   s_amaf_count,
    input  logic [FW-1:0]   s_amaf_mean,
    input  logic [FW-1:0]   s_owner_win_rate,
    input  logic [FW-1:0]   s_color_own_rate,
    input  logic            m_valid,
    input  logic            m_ready,
    input  logic [FW-1:0]   m_blended_value,
    output int              fail_count,
    output int              pending,
    output int              blends_seen
);

    logic [EQW-1:0] equiv_reg;
    logic [THW-1:0] thresh_reg;
    logic [FW-1:0]  blend_q[$];

    function automatic logic [63:0] fx(input logic [FW-1:0] v);
        return (v > ONE) ? 64'(ONE) : 64'(v);
    endfunction

    function automatic logic [FW-1:0] blend_value(input logic [CW-1:0] vc,
                                                  input logic [FW-1:0] mv,
                                                  input logic [CW-1:0] ac,
                                                  input logic [FW-1:0] am, ow_i, co_i);
        logic [63:0] n, q, an, aq, ow, co, nr, qa, eq, prod, d, t, b, acc, mag, cm, crit;
        logic signed [63:0] c2;
        n = 64'(vc); q = fx(mv); an = 64'(ac); aq = fx(am); ow = fx(ow_i); co = fx(co_i);
        nr = an; qa = aq;
        if (thresh_reg != 0 && n >= 64'(thresh_reg)) begin
            c2 = $signed(ow << FRAC_BITS) - (2 * $signed(co * q) - $signed(co << FRAC_BITS)
                 - $signed(q << FRAC_BITS) + $signed(64'd1 << (2 * FRAC_BITS)));
            mag = (c2 < 0) ? 64'(-c2) : 64'(c2);
            cm = mag >> FRAC_BITS;
            crit = cm * an;
            nr = an + (crit >> FRAC_BITS);
            if (nr > 64'hFFFF_FFFF) nr = 64'hFFFF_FFFF;
            if (c2 > 0 && nr != 0) begin
                qa = (aq * an + crit) / nr;
                if (qa > 64'(ONE)) qa = 64'(ONE);
            end
        end
        eq = (equiv_reg == 0) ? 64'd1 : 64'(equiv_reg);
        prod = n * nr;
        d = n + nr;
        t = prod / eq;
        d = (t > ~d) ? '1 : d + t;
        b = (d == 0) ? 64'd0 : (nr << FRAC_BITS) / d;
        if (b > 64'(ONE)) b = 64'(ONE);
        acc = (64'(ONE) - b) * q + b * qa + 64'(HALF);
        return FW'(acc >> FRAC_BITS);
    endfunction

    task automatic report_mismatch(input string what, input logic [FW-1:0] got, exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            equiv_reg  <= EQUIV_RESET;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_EQUIV) equiv_reg <= cfg_wdata[EQW-1:0];
            else if (cfg_index == CFG_THRESH) thresh_reg <= cfg_wdata[THW-1:0];
        end
    end

    initial begin
        fail_count = 0;
        blends_seen = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                blend_q.push_back(blend_value(s_visit_count, s_mean_value, s_amaf_count,
                                              s_amaf_mean, s_owner_win_rate, s_color_own_rate));
            if (m_valid && m_ready) begin
                blends_seen++;
                if (blend_q.size() == 0)
                    report_mismatch("unexpected word", m_blended_value, '0);
                else if (m_blended_value !== blend_q[0]) begin
                    report_mismatch("blended_value", m_blended_value, blend_q[0]);
                    void'(blend_q.pop_front());
                end else
                    void'(blend_q.pop_front());
            end
        end
        pending = blend_q.size();
    end

endmodule

@@ dv/rave_value_blend_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rave_value_blend_top_tb
// Directed corner words and random moves through the blend pipeline under
// several register settings and back-pressure mixes; a checker compares.
// ----------------------------------------------------------------------------
module rave_value_blend_top_tb;
    import rvb_pkg::*;

    localparam int LATENCY = 89;
    localparam int LIMIT   = 400000;

    logic            aclk;
    logic            aresetn;
    logic            cfg_wr_en;
    logic [IDXW-1:0] cfg_index;
    logic [DATW-1:0] cfg_wdata;
    logic            s_valid, s_ready, m_valid, m_ready;
    logic [CW-1:0]   s_visit_count, s_amaf_count;
    logic [FW-1:0]   s_mean_value, s_amaf_mean, s_owner_win_rate, s_color_own_rate;
    logic [FW-1:0]   m_blended_value;
    int              fail_count, pending, blends_seen;
    int              s_idle_pct, m_idle_pct, cycles, words_sent;

    rave_value_blend_top u_top (.*);

    rave_value_blend_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout");
                $display("rave_value_blend_top regression: fail");
                $finish;
            end
        end
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= m_idle_pct);

    function automatic logic [FW-1:0] rand_frac();
        case ($urandom_range(9))
            0: return ONE;
            1: return '0;
            2: return FW'($urandom);
            default: return FW'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_count();
        case ($urandom_range(5))
            0: return '1;
            1: return '0;
            2: return $urandom;
            3: return $urandom_range(100);
            default: return $urandom_range(100000);
        endcase
    endfunction

    task automatic send_move(input logic [CW-1:0] n, input logic [FW-1:0] q,
                             input logic [CW-1:0] an, input logic [FW-1:0] aq, ow, co);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_visit_count    <= n;
        s_mean_value     <= q;
        s_amaf_count     <= an;
        s_amaf_mean      <= aq;
        s_owner_win_rate <= ow;
        s_color_own_rate <= co;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [DATW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_moves(input int count);
        repeat (count)
            send_move(rand_count(), rand_frac(), rand_count(), rand_frac(),
                      rand_frac(), rand_frac());
    endtask

    initial begin
        aresetn = 0; cfg_wr_en = 0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 0; m_ready = 0;
        s_visit_count = '0; s_mean_value = '0; s_amaf_count = '0;
        s_amaf_mean = '0; s_owner_win_rate = '0; s_color_own_rate = '0;
        s_idle_pct = 32; m_idle_pct = 83; words_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero denominators, clamps, saturation, criticality on/off
        send_move('0, ONE, '0, '0, '0, '0);
        send_move('1, ONE, '1, ONE, ONE, ONE);
        send_move('1, '1, '1, '1, '1, '1);
        send_move(100, 30000, 0, 50000, 0, 0);
        send_move(0, 20000, 500, 40000, 0, 0);
        drain();
        write_reg(CFG_THRESH, 1);
        write_reg(CFG_EQUIV, 0);
        send_move('1, ONE, '1, ONE, ONE, '0);
        send_move(5, '0, '1, ONE, ONE, ONE);
        send_move(5, '0, 1000, 0, ONE, '0);
        send_move(5, ONE, 0, ONE, '0, ONE);
        send_move(0, 32768, 10, 32768, 32768, 32768);
        send_move(1, ONE, 1, 0, ONE, 0);
        drain();
        write_reg(CFG_EQUIV, 20'hFFFFF);
        write_reg(CFG_THRESH, 32'hFFFF_FFFF);
        send_move('1, 1, 3, 2, ONE, 0);
        send_move('1 - 1, 1, 3, 2, ONE, 0);
        drain();

        write_reg(CFG_EQUIV, 1);
        write_reg(CFG_THRESH, 50);
        random_moves(250);
        drain();
        s_idle_pct = 83; m_idle_pct = 32;
        write_reg(CFG_EQUIV, 1000000);
        write_reg(CFG_THRESH, 0);
        random_moves(250);
        drain();
        s_idle_pct = 0; m_idle_pct = 0;
        write_reg(CFG_EQUIV, 3000);
        write_reg(CFG_THRESH, 1000);
        random_moves(250);
        drain();
        write_reg(CFG_EQUIV, $urandom_range(1000000));
        write_reg(CFG_THRESH, $urandom);
        random_moves(250);
        drain();

        $display("sent %0d moves, checked %0d blended words, %0d mismatches",
                 words_sent, blends_seen, fail_count);
        $display("covered register corners, criticality raise, saturation and stalls");
        if (fail_count == 0 && pending == 0)
            $display("rave_value_blend_top regression: pass");
        else
            $display("rave_value_blend_top regression: fail");
        $finish;
    end

endmodule
